[rtl/timed_lift_position_controller_core_assert.svh]
// Assertion macros shared by the lift controller modules.
`ifndef TIMED_LIFT_POSITION_CONTROLLER_CORE_ASSERT_SVH
`define TIMED_LIFT_POSITION_CONTROLLER_CORE_ASSERT_SVH

// Condition holds at every clock edge out of reset.
`define TLPC_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define TLPC_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

[rtl/tlpc_pkg.sv]
package tlpc_pkg;

    // Height fixed point: percent with HEIGHT_FRAC_BITS fraction bits.
    localparam int HEIGHT_FRAC_BITS = 16;
    localparam int HEIGHT_W         = HEIGHT_FRAC_BITS + 7;
    localparam int OUT_H_W          = 23;
    localparam logic [HEIGHT_W-1:0] FULL_HEIGHT = HEIGHT_W'(100) << HEIGHT_FRAC_BITS;

    localparam int TIME_W    = 32;
    localparam int ELAPSED_W = 16;
    localparam int TRAVEL_W  = 16;
    localparam int GUARD_W   = 8;
    localparam int REQ_W     = 24;
    localparam int CLAMP_W   = ((HEIGHT_W > REQ_W) ? HEIGHT_W : REQ_W) + 1;

    // Elapsed time scaled by 100 percent, and travel-time product.
    localparam int E100_W = ELAPSED_W + 7;
    localparam int DIV_W  = E100_W + HEIGHT_FRAC_BITS;
    localparam int PROD_W = HEIGHT_W + TRAVEL_W;
    localparam int CNT_W  = $clog2(DIV_W + 1);

    localparam logic [TRAVEL_W-1:0] PERCENT_DIVISOR = TRAVEL_W'(100);

    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;
    localparam logic [1:0] REG_RISE  = 2'd0;
    localparam logic [1:0] REG_LOWER = 2'd1;
    localparam logic [1:0] REG_GUARD = 2'd2;

    localparam logic [TRAVEL_W-1:0] RISE_RESET  = TRAVEL_W'(15500);
    localparam logic [TRAVEL_W-1:0] LOWER_RESET = TRAVEL_W'(10500);
    localparam logic [GUARD_W-1:0]  GUARD_RESET = GUARD_W'(5);

    localparam logic KIND_TICK = 1'b0;
    localparam logic KIND_REQ  = 1'b1;

    localparam logic [1:0] HELD_NONE = 2'd0;
    localparam logic [1:0] HELD_UP   = 2'd1;
    localparam logic [1:0] HELD_DOWN = 2'd2;

    // Bit 0 up relay, bit 1 down relay; 0 drives.
    localparam logic [1:0] RELAY_OFF  = 2'b11;
    localparam logic [1:0] RELAY_UP   = 2'b10;
    localparam logic [1:0] RELAY_DOWN = 2'b01;

    localparam logic [1:0] POS_DEC = 2'd0;
    localparam logic [1:0] POS_INC = 2'd1;
    localparam logic [1:0] POS_EQ  = 2'd2;

    localparam logic [1:0] DIV_FOLD    = 2'd0;
    localparam logic [1:0] DIV_RELEASE = 2'd1;
    localparam logic [1:0] DIV_DUR     = 2'd2;

    typedef struct packed {
        logic [TRAVEL_W-1:0] rise;
        logic [TRAVEL_W-1:0] lower;
        logic [GUARD_W-1:0]  guard;
    } t_cfg;

    typedef struct packed {
        logic       latch;
        logic       expire;
        logic       press;
        logic       set_target;
        logic       relay_off;
        logic       dur_mul;
        logic       div_start;
        logic       apply;
        logic [1:0] div_sel;
        logic       load_out;
    } t_cmd;

    typedef struct packed {
        logic is_req;
        logic up_only;
        logic down_only;
        logic btn_none;
        logic held_none;
        logic move_active;
        logic release_ok;
        logic pos_equal;
        logic div_busy;
        logic div_done;
    } t_sts;

endpackage

[rtl/tlpc_in_if.sv]
interface tlpc_in_if
    import tlpc_pkg::*;
();

    logic                    valid;
    logic                    ready;
    logic                    kind;
    logic                    up_press;
    logic                    down_press;
    logic signed [REQ_W-1:0] requested_height;

    modport source (
        output valid, kind, up_press, down_press, requested_height,
        input  ready
    );
    modport sink (
        input  valid, kind, up_press, down_press, requested_height,
        output ready
    );
endinterface

[rtl/tlpc_out_if.sv]
interface tlpc_out_if
    import tlpc_pkg::*;
();

    logic               valid;
    logic               ready;
    logic               relay_up_level;
    logic               relay_down_level;
    logic [1:0]         pos_cmp;
    logic [OUT_H_W-1:0] height_now;
    logic [OUT_H_W-1:0] height_goal;
    logic               notify;

    modport source (
        output valid, relay_up_level, relay_down_level, pos_cmp,
               height_now, height_goal, notify,
        input  ready
    );
    modport sink (
        input  valid, relay_up_level, relay_down_level, pos_cmp,
               height_now, height_goal, notify,
        output ready
    );
endinterface

[rtl/tlpc_div.sv]
module tlpc_div
    import tlpc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [DIV_W-1:0]    i_dividend,
    input  logic [TRAVEL_W-1:0] i_divisor,
    output logic                o_busy,
    output logic                o_done,
    output logic [DIV_W-1:0]    o_quotient
);

    logic                r_busy;
    logic                r_done;
    logic [CNT_W-1:0]    r_cnt;
    logic [TRAVEL_W-1:0] r_rem;
    logic [TRAVEL_W-1:0] r_dvs;
    logic [DIV_W-1:0]    r_quo;

    logic [TRAVEL_W:0]   trial;
    logic                fits;

    // Restoring division, one quotient bit a cycle, MSB first.
    assign trial = {r_rem, r_quo[DIV_W-1]};
    assign fits  = (trial >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIV_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvs <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= fits ? TRAVEL_W'(trial - {1'b0, r_dvs}) : trial[TRAVEL_W-1:0];
            r_quo <= {r_quo[DIV_W-2:0], fits};
        end
    end

    assign o_busy     = r_busy;
    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

[rtl/tlpc_dpath.sv]
`include "timed_lift_position_controller_core_assert.svh"

module tlpc_dpath
    import tlpc_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cfg                    i_cfg,
    input  t_cmd                    i_cmd,
    input  logic                    i_in_kind,
    input  logic                    i_in_up,
    input  logic                    i_in_down,
    input  logic signed [REQ_W-1:0] i_in_req,
    output t_sts                    o_sts,
    output logic                    o_relay_up,
    output logic                    o_relay_down,
    output logic [1:0]              o_pos_state,
    output logic [OUT_H_W-1:0]      o_height_now,
    output logic [OUT_H_W-1:0]      o_height_goal,
    output logic                    o_notify
);

    // Persistent state
    logic [TIME_W-1:0]    r_time;
    logic [1:0]           r_held;
    logic [TIME_W-1:0]    r_press;
    logic [ELAPSED_W-1:0] r_hold_start;
    logic                 r_move_active;
    logic                 r_move_up;
    logic [ELAPSED_W-1:0] r_move_start;
    logic [ELAPSED_W-1:0] r_move_dur;
    logic [HEIGHT_W-1:0]  r_cur;
    logic [HEIGHT_W-1:0]  r_tgt;
    logic [1:0]           r_relay;
    logic                 r_notify;
    logic                 r_dur_up;

    // Latched beat and working values
    logic                    r_kind;
    logic                    r_up;
    logic                    r_down;
    logic signed [REQ_W-1:0] r_req;
    logic [PROD_W-1:0]       r_prod;

    logic [ELAPSED_W-1:0] move_elapsed;
    logic [ELAPSED_W-1:0] hold_elapsed;
    logic [ELAPSED_W-1:0] sel_elapsed;
    logic [E100_W-1:0]    e100;
    logic [TRAVEL_W-1:0]  travel;
    logic                 travel_up;
    logic [DIV_W-1:0]     dividend;
    logic [TRAVEL_W-1:0]  divisor;
    logic                 div_busy;
    logic                 div_done;
    logic [DIV_W-1:0]     quotient;
    logic                 expire_hit;
    logic                 cur_up;
    logic [HEIGHT_W-1:0]  diff;
    logic [TRAVEL_W-1:0]  dur_travel;
    logic [HEIGHT_W-1:0]  fold_pos;
    logic [HEIGHT_W-1:0]  release_pos;
    logic [1:0]           pos_state;

    function automatic logic [HEIGHT_W-1:0] clamp_req(input logic signed [REQ_W-1:0] req);
        logic signed [CLAMP_W-1:0] v;
        logic signed [CLAMP_W-1:0] full;
        v    = CLAMP_W'(req);
        full = signed'(CLAMP_W'(FULL_HEIGHT));
        if (v < 0) begin
            return '0;
        end else if (v > full) begin
            return FULL_HEIGHT;
        end
        return v[HEIGHT_W-1:0];
    endfunction

    function automatic logic [HEIGHT_W-1:0] clamp_adv(
        input logic [HEIGHT_W-1:0] pos,
        input logic [DIV_W-1:0]    step,
        input logic                up
    );
        logic [HEIGHT_W-1:0] room;
        room = FULL_HEIGHT - pos;
        if (up) begin
            return (step > DIV_W'(room)) ? FULL_HEIGHT : pos + step[HEIGHT_W-1:0];
        end
        return (step > DIV_W'(pos)) ? '0 : pos - step[HEIGHT_W-1:0];
    endfunction

    assign move_elapsed = r_time[ELAPSED_W-1:0] - r_move_start;
    assign hold_elapsed = r_time[ELAPSED_W-1:0] - r_hold_start;
    assign expire_hit   = r_move_active && (move_elapsed >= r_move_dur);

    // Travel step: elapsed * FULL / T, with a zero travel time taken as one.
    assign travel_up   = (i_cmd.div_sel == DIV_FOLD) ? r_move_up : (r_held == HELD_UP);
    assign sel_elapsed = (i_cmd.div_sel == DIV_FOLD) ? move_elapsed : hold_elapsed;
    assign e100        = E100_W'(sel_elapsed) * E100_W'(100);
    assign travel      = travel_up ? i_cfg.rise : i_cfg.lower;

    always_comb begin
        if (i_cmd.div_sel == DIV_DUR) begin
            dividend = DIV_W'(r_prod[PROD_W-1:HEIGHT_FRAC_BITS]);
            divisor  = PERCENT_DIVISOR;
        end else begin
            dividend = {e100, {HEIGHT_FRAC_BITS{1'b0}}};
            divisor  = (travel == '0) ? TRAVEL_W'(1) : travel;
        end
    end

    tlpc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (dividend),
        .i_divisor  (divisor),
        .o_busy     (div_busy),
        .o_done     (div_done),
        .o_quotient (quotient)
    );

    assign cur_up      = (r_cur < r_tgt);
    assign diff        = cur_up ? r_tgt - r_cur : r_cur - r_tgt;
    assign dur_travel  = cur_up ? i_cfg.rise : i_cfg.lower;
    assign fold_pos    = clamp_adv(r_cur, quotient, r_move_up);
    assign release_pos = clamp_adv(r_cur, quotient, r_held == HELD_UP);

    always_comb begin
        if (r_cur > r_tgt) begin
            pos_state = POS_DEC;
        end else if (r_cur < r_tgt) begin
            pos_state = POS_INC;
        end else begin
            pos_state = POS_EQ;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time        <= '0;
            r_held        <= HELD_NONE;
            r_press       <= '0;
            r_hold_start  <= '0;
            r_move_active <= 1'b0;
            r_move_up     <= 1'b0;
            r_move_start  <= '0;
            r_move_dur    <= '0;
            r_cur         <= '0;
            r_tgt         <= '0;
            r_relay       <= RELAY_OFF;
            r_notify      <= 1'b0;
            r_dur_up      <= 1'b0;
        end else begin
            if (i_cmd.latch) begin
                r_notify <= 1'b0;
                if (i_in_kind == KIND_TICK) begin
                    r_time <= r_time + TIME_W'(1);
                end
            end
            // End a timed move whose run time is used up
            if (i_cmd.expire && expire_hit) begin
                r_move_active <= 1'b0;
                r_relay       <= RELAY_OFF;
                r_cur         <= r_tgt;
                r_notify      <= 1'b1;
            end
            if (i_cmd.press) begin
                if (r_up && (r_held != HELD_UP)) begin
                    r_held       <= HELD_UP;
                    r_press      <= r_time;
                    r_hold_start <= r_time[ELAPSED_W-1:0];
                    r_relay      <= RELAY_UP;
                end else if (!r_up && (r_held != HELD_DOWN)) begin
                    r_held       <= HELD_DOWN;
                    r_press      <= r_time;
                    r_hold_start <= r_time[ELAPSED_W-1:0];
                    r_relay      <= RELAY_DOWN;
                end
            end
            if (i_cmd.set_target) begin
                r_tgt <= clamp_req(r_req);
            end
            if (i_cmd.relay_off) begin
                r_relay <= RELAY_OFF;
            end
            if (i_cmd.dur_mul) begin
                r_dur_up <= cur_up;
            end
            if (i_cmd.apply) begin
                unique case (i_cmd.div_sel)
                    DIV_FOLD: begin
                        r_cur         <= fold_pos;
                        r_move_active <= 1'b0;
                    end
                    DIV_RELEASE: begin
                        r_cur        <= release_pos;
                        r_tgt        <= release_pos;
                        r_hold_start <= '0;
                        r_held       <= HELD_NONE;
                        r_relay      <= RELAY_OFF;
                        r_notify     <= 1'b1;
                    end
                    DIV_DUR: begin
                        r_move_dur    <= quotient[ELAPSED_W-1:0];
                        r_relay       <= r_dur_up ? RELAY_UP : RELAY_DOWN;
                        r_move_up     <= r_dur_up;
                        r_move_active <= 1'b1;
                        r_move_start  <= r_time[ELAPSED_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_kind <= i_in_kind;
            r_up   <= i_in_up;
            r_down <= i_in_down;
            r_req  <= i_in_req;
        end
        if (i_cmd.dur_mul) begin
            r_prod <= PROD_W'(diff) * PROD_W'(dur_travel);
        end
        if (i_cmd.load_out) begin
            o_relay_up    <= r_relay[0];
            o_relay_down  <= r_relay[1];
            o_pos_state   <= pos_state;
            o_height_now  <= OUT_H_W'(r_cur);
            o_height_goal <= OUT_H_W'(r_tgt);
            o_notify      <= r_notify;
        end
    end

    assign o_sts.is_req      = (r_kind == KIND_REQ);
    assign o_sts.up_only     = r_up && !r_down;
    assign o_sts.down_only   = r_down && !r_up;
    assign o_sts.btn_none    = !r_up && !r_down;
    assign o_sts.held_none   = (r_held == HELD_NONE);
    assign o_sts.move_active = r_move_active;
    assign o_sts.release_ok  = (r_held != HELD_NONE) &&
                               ((r_time - r_press) > TIME_W'(i_cfg.guard));
    assign o_sts.pos_equal   = (r_cur == r_tgt);
    assign o_sts.div_busy    = div_busy;
    assign o_sts.div_done    = div_done;

    `TLPC_ASSERT_ALWAYS(a_relay_exclusive, i_clk, i_rst_n, r_relay != 2'b00, "both relays drive")
    `TLPC_ASSERT_ALWAYS(a_cur_in_range, i_clk, i_rst_n, r_cur <= FULL_HEIGHT, "height above full")
    `TLPC_ASSERT_IMPLY(a_move_drives, i_clk, i_rst_n, r_move_active, r_relay != RELAY_OFF, "move without relay")

endmodule

[rtl/tlpc_ctrl.sv]
`include "timed_lift_position_controller_core_assert.svh"

module tlpc_ctrl
    import tlpc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_DECODE   = 4'd1;
    localparam logic [3:0] ST_BUTTON   = 4'd2;
    localparam logic [3:0] ST_PRESS    = 4'd3;
    localparam logic [3:0] ST_REQ_FOLD = 4'd4;
    localparam logic [3:0] ST_REQ_CMP  = 4'd5;
    localparam logic [3:0] ST_REQ_DIV  = 4'd6;
    localparam logic [3:0] ST_DIVIDE   = 4'd7;
    localparam logic [3:0] ST_RESULT   = 4'd8;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic [1:0] r_div_sel;
    logic [1:0] n_div_sel;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       out_free;

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == ST_IDLE);

    always_comb begin
        n_state   = r_state;
        n_div_sel = r_div_sel;
        o_cmd     = '0;
        o_cmd.div_sel = r_div_sel;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (!i_sts.is_req) begin
                    o_cmd.expire = 1'b1;
                    n_state      = ST_BUTTON;
                end else if (!i_sts.held_none) begin
                    n_state = ST_RESULT;
                end else begin
                    o_cmd.set_target = 1'b1;
                    n_state          = ST_REQ_FOLD;
                end
            end
            ST_BUTTON: begin
                if (i_sts.up_only || i_sts.down_only) begin
                    if (i_sts.move_active) begin
                        o_cmd.div_start = 1'b1;
                        o_cmd.div_sel   = DIV_FOLD;
                        n_div_sel       = DIV_FOLD;
                        n_state         = ST_DIVIDE;
                    end else begin
                        n_state = ST_PRESS;
                    end
                end else if (i_sts.btn_none && i_sts.release_ok) begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = DIV_RELEASE;
                    n_div_sel       = DIV_RELEASE;
                    n_state         = ST_DIVIDE;
                end else begin
                    n_state = ST_RESULT;
                end
            end
            ST_PRESS: begin
                o_cmd.press = 1'b1;
                n_state     = ST_RESULT;
            end
            ST_REQ_FOLD: begin
                if (i_sts.move_active) begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = DIV_FOLD;
                    n_div_sel       = DIV_FOLD;
                    n_state         = ST_DIVIDE;
                end else begin
                    n_state = ST_REQ_CMP;
                end
            end
            ST_REQ_CMP: begin
                if (i_sts.pos_equal) begin
                    o_cmd.relay_off = 1'b1;
                    n_state         = ST_RESULT;
                end else begin
                    o_cmd.dur_mul = 1'b1;
                    n_state       = ST_REQ_DIV;
                end
            end
            ST_REQ_DIV: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_DUR;
                n_div_sel       = DIV_DUR;
                n_state         = ST_DIVIDE;
            end
            ST_DIVIDE: begin
                if (i_sts.div_done) begin
                    o_cmd.apply = 1'b1;
                    if (r_div_sel == DIV_FOLD) begin
                        n_state = i_sts.is_req ? ST_REQ_CMP : ST_PRESS;
                    end else begin
                        n_state = ST_RESULT;
                    end
                end
            end
            ST_RESULT: begin
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_div_sel   <= DIV_FOLD;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_div_sel   <= n_div_sel;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    `TLPC_ASSERT_IMPLY(a_start_idle_div, i_clk, i_rst_n, o_cmd.div_start, !i_sts.div_busy, "divider restarted while busy")
    `TLPC_ASSERT_IMPLY(a_load_free, i_clk, i_rst_n, o_cmd.load_out, out_free, "result overwritten")
    `TLPC_ASSERT_IMPLY(a_idle_no_div, i_clk, i_rst_n, r_state == ST_IDLE, !i_sts.div_busy, "divider busy while idle")

endmodule

[rtl/timed_lift_position_controller_core.sv]
// Timed lift position controller. Drives the up and down relays of a lift
// and estimates its height from travel time alone. Every input beat is either
// a one-millisecond tick carrying both button levels, or a set-target request;
// every input beat yields exactly one result beat with the relay pin levels
// (0 drives), the current/target comparison, both heights in 1/65536 percent
// and a notify flag that marks a status report (release accepted or timed
// move finished). Travel times and the release guard are written over the
// APB port at 0x0 (full rise ms), 0x4 (full lower ms) and 0x8 (guard ms);
// the user must write them only while the block is idle, which the block
// does not enforce. Items are handled one at a time by a sequencer driving
// a shared radix-2 divider of 39 steps, and the divides set the cost. A tick
// needs one divide when it presses during a running move or accepts a
// release, and none otherwise; a request needs none when the height already
// matches, one when it starts a move, and up to two when it must fold a
// running move before computing the new run time. Output stalls add to this
// cost. The next beat is taken while a finished result still waits in the
// output register.
module timed_lift_position_controller_core
    import tlpc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    tlpc_in_if.sink           i_in,
    tlpc_out_if.source        o_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    t_cfg       r_cfg;
    t_cmd       cmd;
    t_sts       sts;
    logic [1:0] reg_idx;
    logic       cfg_write;

    // Register file: word addressed, writes land in the access phase.
    assign pready    = 1'b1;
    assign reg_idx   = paddr[ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rise  <= RISE_RESET;
            r_cfg.lower <= LOWER_RESET;
            r_cfg.guard <= GUARD_RESET;
        end else if (cfg_write) begin
            unique case (reg_idx)
                REG_RISE:  r_cfg.rise  <= pwdata[TRAVEL_W-1:0];
                REG_LOWER: r_cfg.lower <= pwdata[TRAVEL_W-1:0];
                REG_GUARD: r_cfg.guard <= pwdata[GUARD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_RISE:  prdata = DATA_W'(r_cfg.rise);
            REG_LOWER: prdata = DATA_W'(r_cfg.lower);
            REG_GUARD: prdata = DATA_W'(r_cfg.guard);
            default:   prdata = '0;
        endcase
    end

    // Sequencer: owns the handshakes and steps the datapath through each beat.
    tlpc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // Datapath: lift state, travel arithmetic and the result register.
    tlpc_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_cmd         (cmd),
        .i_in_kind     (i_in.kind),
        .i_in_up       (i_in.up_press),
        .i_in_down     (i_in.down_press),
        .i_in_req      (i_in.requested_height),
        .o_sts         (sts),
        .o_relay_up    (o_out.relay_up_level),
        .o_relay_down  (o_out.relay_down_level),
        .o_pos_state   (o_out.pos_cmp),
        .o_height_now  (o_out.height_now),
        .o_height_goal (o_out.height_goal),
        .o_notify      (o_out.notify)
    );

endmodule
